/* rtl/jsd_pkg.sv */
// shared types and constants of the jpeg stream deframer
package jsd_pkg;

  localparam int FrameCountBitsDef = 22;
  localparam int MaxFrameWidth     = 22;
  localparam int MaxFrameReset     = 2 * 1024 * 1024;
  localparam int HeaderLen         = 12;
  localparam int MaxResults        = 3;
  localparam int ResFifoDepth      = 4;

  localparam logic [7:0] ByteFf  = 8'hFF;
  localparam logic [7:0] ByteSoi = 8'hD8;
  localparam logic [7:0] ByteEoi = 8'hD9;
  localparam logic [7:0] SigM    = 8'h4D;
  localparam logic [7:0] SigO    = 8'h4F;
  localparam logic [7:0] SigR    = 8'h52;
  localparam logic [7:0] SigNul  = 8'h00;

  // configuration register indexes
  localparam logic [1:0] CfgMaxFrame  = 2'd0;
  localparam logic [1:0] CfgLenEnable = 2'd1;
  localparam logic [1:0] CfgMrkEnable = 2'd2;

  typedef enum logic [5:0] {
    ModeHunt      = 6'b000001,
    ModeHeader    = 6'b000010,
    ModePayFirst  = 6'b000100,
    ModePaySecond = 6'b001000,
    ModePayload   = 6'b010000,
    ModeMarked    = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_end;
    logic       frame_abort;
    logic       by_length_header;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [31:0] limit;
    logic        len_en;
    logic        mrk_en;
  } cfg_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] k);
    logic [7:0] r;
    unique case (k)
      2'd0:    r = SigM;
      2'd1:    r = SigO;
      2'd2:    r = SigR;
      default: r = SigNul;
    endcase
    return r;
  endfunction

  function automatic result_t mk_res(input logic [7:0] b, input logic st, input logic en,
                                     input logic ab, input logic bl);
    result_t r;
    r.out_byte         = b;
    r.frame_start      = st;
    r.frame_end        = en;
    r.frame_abort      = ab;
    r.by_length_header = bl;
    r.last_of_run      = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/jsd_core.sv */
// framing state machine: one byte in, up to three results out
module jsd_core #(
  parameter int FRAME_COUNT_BITS = jsd_pkg::FrameCountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  logic [7:0]                    data_byte_i,
  input  jsd_pkg::cfg_t                 cfg_i,
  output logic [1:0]                    res_n_o,
  output jsd_pkg::result_t [2:0]        res_o
);

  localparam int BrW = jsd_pkg::MaxFrameWidth;

  jsd_pkg::mode_e              mode_q, mode_d;
  logic [3:0]                  hi_q, hi_d;
  logic [1:0]                  sm_q, sm_d;
  logic [31:0]                 lw_q, lw_d;
  logic [BrW-1:0]              br_q, br_d;
  logic [FRAME_COUNT_BITS-1:0] fc_q, fc_d;
  logic [7:0]                  pb_q, pb_d;
  logic                        pv_q, pv_d;

  logic                        fc_full;
  logic                        lim_ge2;
  logic                        prev_ff;
  logic                        ends;
  logic [BrW-1:0]              br_dec;
  jsd_pkg::result_t [2:0]      res;
  logic [1:0]                  n;
  logic [7:0]                  b;

  always_comb begin
    b       = data_byte_i;
    mode_d  = mode_q;
    hi_d    = hi_q;
    sm_d    = sm_q;
    lw_d    = lw_q;
    br_d    = br_q;
    fc_d    = fc_q;
    pb_d    = pb_q;
    pv_d    = pv_q;
    res     = '0;
    n       = 2'd0;
    fc_full = 32'(fc_q) >= cfg_i.limit;
    lim_ge2 = cfg_i.limit >= 32'd2;
    prev_ff = pv_q && (pb_q == jsd_pkg::ByteFf);
    ends    = 1'b0;
    br_dec  = (br_q != '0) ? br_q - BrW'(1) : br_q;
    if (in_fire_i) begin
      unique case (mode_q)
        jsd_pkg::ModeHeader: begin
          if (hi_q >= 4'd8) lw_d[8*hi_q[1:0] +: 8] = b;
          if (hi_q >= 4'(jsd_pkg::HeaderLen - 1)) begin
            if (lw_d < 32'd2 || lw_d > cfg_i.limit) begin
              mode_d = jsd_pkg::ModeHunt;
              sm_d   = 2'd0;
              pv_d   = 1'b0;
              hi_d   = 4'd0;
            end else begin
              br_d   = lw_d[BrW-1:0];
              mode_d = jsd_pkg::ModePayFirst;
            end
          end else begin
            hi_d = hi_q + 4'd1;
          end
        end
        jsd_pkg::ModePayFirst: begin
          pb_d   = b;
          pv_d   = 1'b1;
          mode_d = jsd_pkg::ModePaySecond;
        end
        jsd_pkg::ModePaySecond: begin
          if (pb_q == jsd_pkg::ByteFf && b == jsd_pkg::ByteSoi &&
              br_q >= BrW'(2) && lim_ge2) begin
            res[0] = jsd_pkg::mk_res(jsd_pkg::ByteFf, 1'b1, 1'b0, 1'b0, 1'b1);
            res[1] = jsd_pkg::mk_res(jsd_pkg::ByteSoi, 1'b0, br_q == BrW'(2), 1'b0, 1'b1);
            n      = 2'd2;
            fc_d   = FRAME_COUNT_BITS'(2);
            br_d   = br_q - BrW'(2);
            if (br_q == BrW'(2)) begin
              mode_d = jsd_pkg::ModeHunt;
              sm_d   = 2'd0;
              pv_d   = 1'b0;
              hi_d   = 4'd0;
            end else begin
              mode_d = jsd_pkg::ModePayload;
            end
          end else begin
            mode_d = jsd_pkg::ModeHunt;
            sm_d   = 2'd0;
            pv_d   = 1'b0;
            hi_d   = 4'd0;
          end
        end
        jsd_pkg::ModePayload: begin
          if (fc_full) begin
            res[0] = jsd_pkg::mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
            n      = 2'd1;
            mode_d = jsd_pkg::ModeHunt;
            sm_d   = 2'd0;
            pv_d   = 1'b0;
            hi_d   = 4'd0;
          end else begin
            fc_d   = fc_q + FRAME_COUNT_BITS'(1);
            res[0] = jsd_pkg::mk_res(b, 1'b0, br_q <= BrW'(1), 1'b0, 1'b1);
            n      = 2'd1;
            br_d   = br_dec;
            if (br_dec == '0) begin
              mode_d = jsd_pkg::ModeHunt;
              sm_d   = 2'd0;
              pv_d   = 1'b0;
              hi_d   = 4'd0;
            end
          end
        end
        jsd_pkg::ModeMarked: begin
          if (prev_ff && b == jsd_pkg::ByteSoi) begin
            // restart inside a marker frame
            res[0] = jsd_pkg::mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
            n      = 2'd1;
            if (lim_ge2) begin
              res[1] = jsd_pkg::mk_res(jsd_pkg::ByteFf, 1'b1, 1'b0, 1'b0, 1'b0);
              res[2] = jsd_pkg::mk_res(jsd_pkg::ByteSoi, 1'b0, 1'b0, 1'b0, 1'b0);
              n      = 2'd3;
              fc_d   = FRAME_COUNT_BITS'(2);
              sm_d   = 2'd0;
              pb_d   = b;
              pv_d   = 1'b1;
            end else begin
              mode_d = jsd_pkg::ModeHunt;
              sm_d   = 2'd0;
              pv_d   = 1'b0;
              hi_d   = 4'd0;
            end
          end else begin
            ends = prev_ff && b == jsd_pkg::ByteEoi;
            if (fc_full) begin
              res[0] = jsd_pkg::mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
              n      = 2'd1;
              mode_d = jsd_pkg::ModeHunt;
              sm_d   = 2'd0;
              pv_d   = 1'b0;
              hi_d   = 4'd0;
            end else begin
              fc_d   = fc_q + FRAME_COUNT_BITS'(1);
              res[0] = jsd_pkg::mk_res(b, 1'b0, ends, 1'b0, 1'b0);
              n      = 2'd1;
              if (ends) begin
                mode_d = jsd_pkg::ModeHunt;
                sm_d   = 2'd0;
                pv_d   = 1'b0;
                hi_d   = 4'd0;
              end else begin
                pb_d = b;
                pv_d = 1'b1;
              end
            end
          end
        end
        default: begin
          // hunting, and any broken mode code
          mode_d = jsd_pkg::ModeHunt;
          if (cfg_i.mrk_en && prev_ff && b == jsd_pkg::ByteSoi && lim_ge2) begin
            res[0] = jsd_pkg::mk_res(jsd_pkg::ByteFf, 1'b1, 1'b0, 1'b0, 1'b0);
            res[1] = jsd_pkg::mk_res(jsd_pkg::ByteSoi, 1'b0, 1'b0, 1'b0, 1'b0);
            n      = 2'd2;
            fc_d   = FRAME_COUNT_BITS'(2);
            mode_d = jsd_pkg::ModeMarked;
            sm_d   = 2'd0;
            pb_d   = b;
            pv_d   = 1'b1;
          end else if (cfg_i.len_en && b == jsd_pkg::sig_byte(sm_q) && sm_q == 2'd3) begin
            mode_d = jsd_pkg::ModeHeader;
            hi_d   = 4'd4;
            lw_d   = '0;
            sm_d   = 2'd0;
            pv_d   = 1'b0;
          end else begin
            if (!cfg_i.len_en) sm_d = 2'd0;
            else if (b == jsd_pkg::sig_byte(sm_q)) sm_d = sm_q + 2'd1;
            else sm_d = (b == jsd_pkg::SigM) ? 2'd1 : 2'd0;
            pb_d = b;
            pv_d = 1'b1;
          end
        end
      endcase
    end
    unique case (n)
      2'd1:    res[0].last_of_run = 1'b1;
      2'd2:    res[1].last_of_run = 1'b1;
      2'd3:    res[2].last_of_run = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsd_pkg::ModeHunt;
      hi_q   <= '0;
      sm_q   <= '0;
      lw_q   <= '0;
      br_q   <= '0;
      fc_q   <= '0;
      pb_q   <= '0;
      pv_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      hi_q   <= hi_d;
      sm_q   <= sm_d;
      lw_q   <= lw_d;
      br_q   <= br_d;
      fc_q   <= fc_d;
      pb_q   <= pb_d;
      pv_q   <= pv_d;
    end
  end

  assign res_n_o = n;
  assign res_o   = res;

endmodule

/* rtl/jsd_res_fifo.sv */
// small result queue, takes up to three results a cycle and gives one
module jsd_res_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             push_n_i,
  input  jsd_pkg::result_t [2:0] push_data_i,
  input  logic                   pop_i,
  output logic                   out_valid_o,
  output jsd_pkg::result_t       head_o,
  output logic                   space_o
);

  localparam int Depth = jsd_pkg::ResFifoDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  jsd_pkg::result_t    mem [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  assign pop         = pop_i && (cnt_q != '0);
  assign cnt_d       = cnt_q + CntW'(push_n_i) - CntW'(pop);
  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem[rd_q];
  assign space_o     = cnt_q <= CntW'(Depth - jsd_pkg::MaxResults);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < jsd_pkg::MaxResults; i++) begin
      if (i < int'(push_n_i)) mem[wr_q + PtrW'(i)] <= push_data_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_n_i);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (CntW'(push_n_i) + cnt_q <= CntW'(Depth)))
    else $error("result queue overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result count out of range");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> push_data_i[push_n_i - 2'd1].last_of_run)
    else $error("final result of a byte lacks last flag");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_n_i == 2'd0) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("result count did not drop on pop");
`endif

endmodule

/* rtl/jpeg_stream_deframer_top.sv */
// jpeg stream deframer: header or marker framing of a camera byte stream
// results are registered in the result queue, then offered in order behind earlier beats
// throughput: one byte per cycle while each byte yields at most one result and no
//   beat is stalled; the result port drains one beat per cycle, so a byte that yields
//   two or three results holds the input until the four-entry result queue has room
// reset: rst_ni async active low; hunting state, registers at their reset values
module jpeg_stream_deframer_top #(
  parameter int FRAME_COUNT_BITS = jsd_pkg::FrameCountBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        data_byte_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        out_byte_o,
  output logic                              frame_start_o,
  output logic                              frame_end_o,
  output logic                              frame_abort_o,
  output logic                              by_length_header_o,
  output logic                              last_of_run_o,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [jsd_pkg::MaxFrameWidth-1:0] cfg_data_i
);

  // largest value the frame counter holds
  localparam logic [31:0] CountMax = 32'((64'd1 << FRAME_COUNT_BITS) - 64'd1);
  localparam logic [31:0] LimitReset =
    (32'(jsd_pkg::MaxFrameReset) < CountMax) ? 32'(jsd_pkg::MaxFrameReset) : CountMax;

  // effective frame limit is kept already clipped to the counter range
  logic [31:0]            limit_q;
  logic                   len_en_q;
  logic                   mrk_en_q;
  jsd_pkg::cfg_t          cfg;

  logic                   in_fire;
  logic [1:0]             res_n;
  jsd_pkg::result_t [2:0] res;
  jsd_pkg::result_t       head;
  logic                   space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LimitReset;
      len_en_q <= 1'b1;
      mrk_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        jsd_pkg::CfgMaxFrame: begin
          limit_q <= (32'(cfg_data_i) < CountMax) ? 32'(cfg_data_i) : CountMax;
        end
        jsd_pkg::CfgLenEnable: len_en_q <= cfg_data_i[0];
        jsd_pkg::CfgMrkEnable: mrk_en_q <= cfg_data_i[0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  assign cfg.limit  = limit_q;
  assign cfg.len_en = len_en_q;
  assign cfg.mrk_en = mrk_en_q;

  // a byte is taken only when the queue can hold its worst-case result burst
  assign in_ready_o = space;
  assign in_fire    = in_valid_i && space;

  jsd_core #(
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .data_byte_i (data_byte_i),
    .cfg_i       (cfg),
    .res_n_o     (res_n),
    .res_o       (res)
  );

  jsd_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (res_n),
    .push_data_i (res),
    .pop_i       (out_ready_i),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .space_o     (space)
  );

  // result beat fields straight from the queue head
  assign out_byte_o         = head.out_byte;
  assign frame_start_o      = head.frame_start;
  assign frame_end_o        = head.frame_end;
  assign frame_abort_o      = head.frame_abort;
  assign by_length_header_o = head.by_length_header;
  assign last_of_run_o      = head.last_of_run;

`ifndef NO_ASSERTIONS
  a_results_need_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_n != 2'd0) |-> in_fire)
    else $error("results produced without an accepted byte");
  a_limit_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q <= CountMax)
    else $error("frame limit above counter range");
  a_start_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_n != 2'd0 && res[0].frame_start) |-> (res_n >= 2'd2 && !res[0].frame_abort))
    else $error("frame start without its marker pair");
`endif

endmodule

/* tb/tb_jpeg_stream_deframer_top.sv */
// jpeg stream deframer testbench: directed and random byte streams checked by a frame predictor
`timescale 1ns / 100ps

module tb_jpeg_stream_deframer_top;
  import jsd_pkg::*;

  // largest value the frame byte counter can hold
  localparam logic [31:0] CountMax = 32'((64'd1 << FrameCountBitsDef) - 64'd1);
  // settle time after the last expected beat, to cover any work still in flight
  localparam int SettleCycles = 4;
  // the receiver holds off once, after this many bytes were taken, for this many cycles
  localparam int HoldAfter = 40;
  localparam int HoldLen   = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        frame_start_o;
  logic        frame_end_o;
  logic        frame_abort_o;
  logic        by_length_header_o;
  logic        last_of_run_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [MaxFrameWidth-1:0] cfg_data_i = '0;

  // predicts the frame beats of each accepted byte and checks the beats that come out
  class frame_scoreboard;
    result_t     expected_q[$];
    result_t     run_q[$];
    int unsigned errors;
    // shadow registers
    logic [21:0] max_frame;
    bit          len_en;
    bit          mrk_en;
    // shadow deframer state
    mode_e       mode;
    logic [3:0]  hdr_idx;
    logic [1:0]  sig_cnt;
    logic [31:0] len_word;
    logic [31:0] remaining;
    logic [21:0] count;
    logic [7:0]  prev_byte;
    bit          prev_ok;

    function new();
      errors    = 0;
      max_frame = 22'(MaxFrameReset);
      len_en    = 1'b1;
      mrk_en    = 1'b1;
      mode      = ModeHunt;
      hdr_idx   = '0;
      sig_cnt   = '0;
      len_word  = '0;
      remaining = '0;
      count     = '0;
      prev_byte = '0;
      prev_ok   = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [21:0] val);
      case (idx)
        CfgMaxFrame:  max_frame = val;
        CfgLenEnable: len_en = val[0];
        CfgMrkEnable: mrk_en = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [31:0] limit();
      logic [31:0] m;
      m = {10'b0, max_frame};
      return (m < CountMax) ? m : CountMax;
    endfunction

    function logic [7:0] sig_at(logic [1:0] k);
      case (k)
        2'd0:    return SigM;
        2'd1:    return SigO;
        2'd2:    return SigR;
        default: return SigNul;
      endcase
    endfunction

    function void emit(logic [7:0] b, bit st, bit en, bit ab, bit bl);
      result_t r;
      if (run_q.size() >= MaxResults) return;
      r.out_byte         = b;
      r.frame_start      = st;
      r.frame_end        = en;
      r.frame_abort      = ab;
      r.by_length_header = bl;
      r.last_of_run      = 1'b0;
      run_q.push_back(r);
    endfunction

    function void go_hunt();
      mode    = ModeHunt;
      sig_cnt = '0;
      prev_ok = 1'b0;
      hdr_idx = '0;
    endfunction

    // one frame byte under the size limit; 0 when the frame aborted instead
    function bit frame_byte(logic [7:0] b, bit en, bit bl);
      if ({10'b0, count} >= limit()) begin
        emit(8'h00, 1'b0, 1'b0, 1'b1, bl);
        go_hunt();
        return 1'b0;
      end
      count = count + 22'd1;
      emit(b, 1'b0, en, 1'b0, bl);
      return 1'b1;
    endfunction

    function void open_marker_frame();
      emit(ByteFf, 1'b1, 1'b0, 1'b0, 1'b0);
      emit(ByteSoi, 1'b0, 1'b0, 1'b0, 1'b0);
      count   = 22'd2;
      mode    = ModeMarked;
      sig_cnt = '0;
    endfunction

    function void hunt_byte(logic [7:0] b);
      if (mrk_en && prev_ok && prev_byte == ByteFf && b == ByteSoi && limit() >= 32'd2) begin
        open_marker_frame();
        prev_byte = b;
        prev_ok   = 1'b1;
        return;
      end
      if (len_en) begin
        if (b == sig_at(sig_cnt)) begin
          if (sig_cnt == 2'd3) begin
            mode     = ModeHeader;
            hdr_idx  = 4'd4;
            len_word = '0;
            sig_cnt  = '0;
            prev_ok  = 1'b0;
            return;
          end
          sig_cnt = sig_cnt + 2'd1;
        end else begin
          sig_cnt = (b == SigM) ? 2'd1 : 2'd0;
        end
      end else begin
        sig_cnt = '0;
      end
      prev_byte = b;
      prev_ok   = 1'b1;
    endfunction

    function void note_byte(logic [7:0] b);
      bit ends;
      run_q.delete();
      case (mode)
        ModeHeader: begin
          if (hdr_idx >= 4'd8 && hdr_idx <= 4'd11)
            len_word = len_word | (32'(b) << ((int'(hdr_idx) - 8) * 8));
          if (hdr_idx >= 4'd11) begin
            if (len_word < 32'd2 || len_word > limit()) begin
              go_hunt();
            end else begin
              remaining = len_word;
              mode      = ModePayFirst;
            end
          end else begin
            hdr_idx = hdr_idx + 4'd1;
          end
        end
        ModePayFirst: begin
          prev_byte = b;
          prev_ok   = 1'b1;
          mode      = ModePaySecond;
        end
        ModePaySecond: begin
          if (prev_byte == ByteFf && b == ByteSoi && remaining >= 32'd2 && limit() >= 32'd2) begin
            emit(ByteFf, 1'b1, 1'b0, 1'b0, 1'b1);
            emit(ByteSoi, 1'b0, remaining == 32'd2, 1'b0, 1'b1);
            count     = 22'd2;
            remaining = remaining - 32'd2;
            if (remaining == 32'd0) go_hunt();
            else mode = ModePayload;
          end else begin
            go_hunt();
          end
        end
        ModePayload: begin
          if (frame_byte(b, remaining <= 32'd1, 1'b1)) begin
            if (remaining > 32'd0) remaining = remaining - 32'd1;
            if (remaining == 32'd0) go_hunt();
          end
        end
        ModeMarked: begin
          if (prev_ok && prev_byte == ByteFf && b == ByteSoi) begin
            emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
            if (limit() >= 32'd2) begin
              open_marker_frame();
              prev_byte = b;
              prev_ok   = 1'b1;
            end else begin
              go_hunt();
            end
          end else begin
            ends = prev_ok && prev_byte == ByteFf && b == ByteEoi;
            if (frame_byte(b, ends, 1'b0)) begin
              if (ends) begin
                go_hunt();
              end else begin
                prev_byte = b;
                prev_ok   = 1'b1;
              end
            end
          end
        end
        default: begin
          mode = ModeHunt;
          hunt_byte(b);
        end
      endcase
      if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected: byte %02h st %0b en %0b ab %0b hdr %0b last %0b",
                 $time, got.out_byte, got.frame_start, got.frame_end, got.frame_abort,
                 got.by_length_header, got.last_of_run);
        return;
      end
      exp = expected_q.pop_front();
      if (got !== exp) begin
        errors++;
        $display("%0t: beat mismatch: expected byte %02h st %0b en %0b ab %0b hdr %0b last %0b",
                 $time, exp.out_byte, exp.frame_start, exp.frame_end, exp.frame_abort,
                 exp.by_length_header, exp.last_of_run);
        $display("%0t:                  actual byte %02h st %0b en %0b ab %0b hdr %0b last %0b",
                 $time, got.out_byte, got.frame_start, got.frame_end, got.frame_abort,
                 got.by_length_header, got.last_of_run);
      end
    endfunction
  endclass

  frame_scoreboard sb = new();

  // bytes still to be sent in the current phase
  logic [7:0] stream_q[$];

  // sender burst state
  int burst_left = 0;
  // bytes taken by the block so far
  int sent_cnt   = 0;

  // receiver pattern state
  bit hold_done = 1'b0;
  int hold_left = 0;
  int pat_mode  = 0;
  int pat_left  = 0;

  jpeg_stream_deframer_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .frame_start_o      (frame_start_o),
    .frame_end_o        (frame_end_o),
    .frame_abort_o      (frame_abort_o),
    .by_length_header_o (by_length_header_o),
    .last_of_run_o      (last_of_run_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // receiver: changes its stall pattern after each run of random length, and once holds off
  // long enough for the result queue to fill and push back on the byte input
  always @(posedge clk_i) begin
    if (!hold_done && sent_cnt >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(8, 40);
      end
      pat_left--;
      case (pat_mode)
        0:       out_ready_i <= 1'b1;                      // no stalls
        1:       out_ready_i <= 1'($urandom_range(0, 1));  // coin flip
        2:       out_ready_i <= ($urandom_range(0, 3) == 0); // mostly stalled
        default: out_ready_i <= (pat_left % 3 != 0);      // regular one-in-three stall
      endcase
    end
  end

  // result monitor: every accepted beat goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({out_byte_o, frame_start_o, frame_end_o, frame_abort_o,
                       by_length_header_o, last_of_run_o});
  end

  // byte mix rich in markers and signature starts
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0:       return ByteFf;
      1:       return ByteSoi;
      2:       return ByteEoi;
      3:       return SigM;
      default: return 8'($urandom);
    endcase
  endfunction

  // signature, reserved bytes and little-endian length
  function automatic void add_header(logic [31:0] len);
    stream_q.push_back(SigM);
    stream_q.push_back(SigO);
    stream_q.push_back(SigR);
    stream_q.push_back(SigNul);
    repeat (4) stream_q.push_back(8'($urandom));
    stream_q.push_back(len[7:0]);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[23:16]);
    stream_q.push_back(len[31:24]);
  endfunction

  // one random piece of stream, mostly well-formed frames with random content
  function automatic void add_chunk();
    int          pick;
    int          n;
    int          i;
    logic [31:0] len;
    logic [7:0]  b0;
    logic [7:0]  b1;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // header frame, mostly short, now and then past a small limit
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(2, 12);
      add_header(len);
      stream_q.push_back(ByteFf);
      stream_q.push_back(ByteSoi);
      for (i = 2; i < int'(len); i++) stream_q.push_back(any_byte());
    end else if (pick < 55) begin
      // marker frame: ended, restarted inside, or left open
      if ($urandom_range(0, 1)) stream_q.push_back(any_byte());
      stream_q.push_back(ByteFf);
      stream_q.push_back(ByteSoi);
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) stream_q.push_back(any_byte());
      case ($urandom_range(0, 6))
        0: ;
        1: begin
          stream_q.push_back(ByteFf);
          stream_q.push_back(ByteSoi);
          stream_q.push_back(any_byte());
          stream_q.push_back(ByteFf);
          stream_q.push_back(ByteEoi);
        end
        default: begin
          stream_q.push_back(ByteFf);
          stream_q.push_back(ByteEoi);
        end
      endcase
    end else if (pick < 65) begin
      // header whose length is out of reach
      case ($urandom_range(0, 4))
        0:       len = 32'd0;
        1:       len = 32'd1;
        2:       len = 32'hFFFF_FFFF;
        3:       len = $urandom;
        default: len = {10'b0, sb.max_frame} + 32'd1;
      endcase
      add_header(len);
    end else if (pick < 75) begin
      // header whose payload does not open with FF D8
      len = $urandom_range(2, 6);
      add_header(len);
      b0 = $urandom_range(0, 1) ? ByteFf : 8'($urandom);
      b1 = 8'($urandom);
      if (b0 == ByteFf && b1 == ByteSoi) b1 = ByteEoi;
      stream_q.push_back(b0);
      stream_q.push_back(b1);
      for (i = 2; i < int'(len); i++) stream_q.push_back(any_byte());
    end else if (pick < 85) begin
      // signature cut short
      n = $urandom_range(1, 3);
      stream_q.push_back(SigM);
      if (n > 1) stream_q.push_back(SigO);
      if (n > 2) stream_q.push_back(SigR);
      stream_q.push_back(any_byte());
    end else begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) stream_q.push_back(any_byte());
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input logic [21:0] maxf, input bit len_on, input bit mrk_on);
    write_reg(CfgMaxFrame, maxf);
    write_reg(CfgLenEnable, 22'(len_on));
    write_reg(CfgMrkEnable, 22'(mrk_on));
    cfg_we_i <= 1'b0;
  endtask

  // sends the queued bytes in bursts of random length with random gaps
  task automatic drive_stream();
    int         gap;
    logic [7:0] b;
    while (stream_q.size() > 0) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          gap        = 0;
          burst_left = 40;
        end else begin
          gap        = $urandom_range(1, 6);
          burst_left = $urandom_range(1, 16);
        end
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      b = stream_q.pop_front();
      in_valid_i  <= 1'b1;
      data_byte_i <= b;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      sb.note_byte(b);
      sent_cnt++;
      burst_left--;
    end
    in_valid_i <= 1'b0;
  endtask

  // idle means every expected beat is back and nothing is left in flight
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [21:0] maxf, input bit len_on, input bit mrk_on,
                           input int nbytes);
    set_config(maxf, len_on, mrk_on);
    while (stream_q.size() < nbytes) add_chunk();
    drive_stream();
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: a four-byte header frame whose payload ends in FF,
    // then a marker frame restarted by a second FF D8 and closed by FF D9
    stream_q = '{SigM, SigO, SigR, SigNul, 8'hA5, 8'h5A, 8'h00, 8'hFF,
                 8'h04, 8'h00, 8'h00, 8'h00, ByteFf, ByteSoi, 8'h00, ByteFf,
                 ByteFf, ByteSoi, ByteFf, ByteSoi, 8'h7E, ByteFf, ByteEoi};
    drive_stream();
    settle();

    // random phases across the register settings, extremes included
    run_phase(22'(MaxFrameReset), 1'b1, 1'b1, 35);
    run_phase(22'd6, 1'b1, 1'b1, 25);                // frame limit hit often
    run_phase(22'h3F_FFFF, 1'b0, 1'b1, 20);          // markers only
    run_phase(22'($urandom_range(2, 20)), 1'b1, 1'b0, 20); // headers only
    run_phase(22'd2, 1'b1, 1'b1, 12);                // smallest legal frame
    run_phase(22'd1, 1'b1, 1'b1, 10);                // limit below two
    run_phase(22'd0, 1'b0, 1'b0, 6);                 // nothing hunted
    run_phase(22'(MaxFrameReset), 1'b1, 1'b1, 20);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
